// ----- src/twe_pkg.sv -----
// Package for the timeout wheel engine: operation codes, register map,
// configuration struct and reset constants. No dependencies.
`default_nettype none
package twe_pkg;

    localparam int NUM_SLOTS_DEF    = 16;
    localparam int BUCKET_COUNT_DEF = 8;
    localparam int BUCKET_SHIFT_DEF = 12;

    localparam logic [2:0] K_INIT     = 3'd0;
    localparam logic [2:0] K_SET      = 3'd1;
    localparam logic [2:0] K_SETAGAIN = 3'd2;
    localparam logic [2:0] K_CANCEL   = 3'd3;
    localparam logic [2:0] K_TICK     = 3'd4;
    localparam logic [2:0] K_UPDATE   = 3'd5;

    localparam logic [1:0] R_ONE_SHOT = 2'd0;
    localparam logic [1:0] R_MIN_INT  = 2'd1;
    localparam logic [1:0] R_HOUSE    = 2'd2;
    localparam logic [1:0] R_GRACE    = 2'd3;

    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        one_shot;
        logic [31:0] min_interval;
        logic        house_tick;
        logic [31:0] grace;
    } cfg_t;

endpackage
`default_nettype wire

// ----- src/timeout_wheel_engine.sv -----
// Timeout wheel engine top level: control sequencer over the slot memory.
// Depends on twe_pkg, twe_cfg, twe_mod, twe_smem.
//
//  port group      direction  handshake
//  command item    in         start & !busy
//  result item     out        result_valid, one cycle, last on completion
//  config          in/out     APB write at psel & penable & pwrite & pready
//
// Init, cancel and out-of-range items finish without a sweep. Update sweeps the
// slots once; a tick runs the remainder unit, then sweeps the slots
// for every expiry and once more, one memory read a cycle.
// Reset is asynchronous; flags and written bits clear at once.
// Results cannot be stalled; busy holds off the next item.
`default_nettype none
module timeout_wheel_engine #(
    parameter int NUM_SLOTS    = twe_pkg::NUM_SLOTS_DEF,
    parameter int BUCKET_COUNT = twe_pkg::BUCKET_COUNT_DEF,
    parameter int BUCKET_SHIFT = twe_pkg::BUCKET_SHIFT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic [3:0]  slot_id,
    input  wire logic [63:0] time_value,
    input  wire logic        ignore_valid,
    input  wire logic [3:0]  ignore_slot,
    output logic             result_valid,
    output logic             event_res,
    output logic [3:0]       result_slot,
    output logic             error,
    output logic             program_valid,
    output logic [63:0]      program_value,
    output logic             any_pending,
    output logic             slot_queued,
    output logic             slot_hit,
    output logic             last
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int DW = 64 + 32 + BW;
    localparam logic [BW-1:0] BONES =
        BW'((64'hFFFF_FFFF_FFFF_FFFF >> BUCKET_SHIFT) % BUCKET_COUNT);
    localparam logic [DW-1:0] RST_WORD = {twe_pkg::TIME_MAX, 32'd0, BONES};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_PROG  = 7'b0001000,
        S_SWEEP = 7'b0010000,
        S_SWEND = 7'b0100000,
        S_DONE  = 7'b1000000
    } st_t;

    twe_pkg::cfg_t cfg;
    st_t           state_reg;
    st_t           state_next;

    logic [2:0]    kind_reg;
    logic [3:0]    sid_reg;
    logic [63:0]   tv_reg;
    logic          ign_reg;
    logic [3:0]    ig_reg;
    logic          ok_reg;
    logic [SW-1:0] idx_reg;
    logic          err_reg;
    logic          pv_reg;
    logic [63:0]   pval_reg;
    logic [63:0]   pc_reg;
    logic [63:0]   last_tick_reg;
    logic [31:0]   sc_reg;
    logic [63:0]   floor_reg;
    logic [63:0]   lim_reg;
    logic [63:0]   wenq_reg;
    logic          full_reg;
    logic [BW:0]   count_reg;
    logic [BW-1:0] first_reg;
    logic [SW:0]   rd_cnt_reg;
    logic          p_vld_reg;
    logic [SW-1:0] p_idx_reg;
    logic          found_reg;
    logic [SW-1:0] best_reg;
    logic [BW:0]   bpos_reg;
    logic [63:0]   bw_reg;
    logic [31:0]   bage_reg;
    logic [63:0]   min_reg;
    logic [NUM_SLOTS-1:0] queued_reg;
    logic [NUM_SLOTS-1:0] hit_reg;

    logic          accept;
    logic [SW+3:0] sid_ext;
    logic [SW-1:0] sid_idx;
    logic          sid_ok;
    logic [SW+3:0] ig_ext;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [SW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic [63:0]   r_w;
    logic [31:0]   r_stamp;
    logic [BW-1:0] r_bkt;
    logic          mod_start;
    logic [63:0]   mod_value;
    logic          mod_done;
    logic [BW-1:0] mod_rem;
    logic [64:0]   floor_sum;
    logic [64:0]   lim_sum;
    logic [63:0]   nb;
    logic [63:0]   sb;
    logic [63:0]   diff;
    logic          full_in;
    logic [31:0]   age;
    logic [BW:0]   pos;
    logic          tick_cand;
    logic          tick_better;
    logic          min_take;
    logic          pend;
    logic          exp_now;
    logic          done_now;
    logic [SW+3:0] best_ext;
    logic [SW+3:0] pidx_ext;
    logic [63:0]   prog_in;
    logic [63:0]   prog_val;

    twe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twe_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (mod_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    twe_smem #(.DEPTH(NUM_SLOTS), .DW(DW), .RST_VAL(RST_WORD)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept  = start & (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign sid_ext = {{SW{1'b0}}, slot_id};
    assign sid_idx = sid_ext[SW-1:0];
    assign sid_ok  = ({3'd0, slot_id} < 7'(NUM_SLOTS));
    assign ig_ext  = {{SW{1'b0}}, ig_reg};

    assign {r_w, r_stamp, r_bkt} = mem_rdata;

    assign floor_sum = {1'b0, last_tick_reg} + {33'd0, cfg.min_interval};
    assign lim_sum   = {1'b0, tv_reg} + {33'd0, cfg.grace};

    assign nb      = time_value >> BUCKET_SHIFT;
    assign sb      = last_tick_reg >> BUCKET_SHIFT;
    assign diff    = nb - sb;
    assign full_in = (nb < sb) || (diff >= 64'(BUCKET_COUNT));

    // sweep element evaluation
    assign age      = sc_reg - r_stamp;
    assign pos      = {1'b0, r_bkt} + ((r_bkt < first_reg) ? (BW+1)'(BUCKET_COUNT) : '0)
                      - {1'b0, first_reg};
    assign tick_cand = queued_reg[p_idx_reg] && (pos < count_reg) && (r_w <= tv_reg);
    assign tick_better = !found_reg || (pos < bpos_reg) ||
                         ((pos == bpos_reg) && ((r_w < bw_reg) ||
                          ((r_w == bw_reg) && (age < bage_reg))));
    assign pidx_ext = {4'd0, p_idx_reg};
    assign min_take = queued_reg[p_idx_reg] &&
                      !((kind_reg == twe_pkg::K_UPDATE) && ign_reg && (pidx_ext == ig_ext)) &&
                      (r_w < min_reg);

    assign prog_in  = (state_reg == S_PROG) ? wenq_reg : min_reg;
    assign prog_val = (prog_in < floor_reg) ? floor_reg : prog_in;

    always_comb
    begin
        pend = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
            if (queued_reg[s] && !(ign_reg && (ig_ext == (SW+4)'(s))))
                pend = 1'b1;
    end

    always_comb
    begin
        mod_start = 1'b0;
        mod_value = sb;
        if (accept && (kind == twe_pkg::K_TICK))
            mod_start = 1'b1;
        else if ((state_reg == S_RD) && (kind_reg == twe_pkg::K_SET) && !queued_reg[idx_reg])
        begin
            mod_start = 1'b1;
            mod_value = tv_reg >> BUCKET_SHIFT;
        end
    end

    always_comb
    begin
        mem_raddr = idx_reg;
        if (state_reg == S_IDLE)
            mem_raddr = sid_idx;
        else if (state_reg == S_SWEEP)
            mem_raddr = rd_cnt_reg[SW-1:0];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {r_w, r_stamp, r_bkt};
        if (state_reg == S_RD)
        begin
            if (kind_reg == twe_pkg::K_INIT)
            begin
                mem_we    = 1'b1;
                mem_wdata = {twe_pkg::TIME_MAX, r_stamp, BONES};
            end
            else if ((kind_reg == twe_pkg::K_SETAGAIN) && !queued_reg[idx_reg] &&
                     !hit_reg[idx_reg])
            begin
                mem_we    = 1'b1;
                mem_wdata = {r_w, sc_reg, r_bkt};
            end
        end
        else if ((state_reg == S_MOD) && (kind_reg == twe_pkg::K_SET) && mod_done)
        begin
            mem_we    = 1'b1;
            mem_wdata = {tv_reg, sc_reg, mod_rem};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (((kind == twe_pkg::K_INIT) || (kind == twe_pkg::K_SET) ||
                         (kind == twe_pkg::K_SETAGAIN)) && sid_ok)
                        state_next = S_RD;
                    else if (kind == twe_pkg::K_TICK)
                        state_next = S_MOD;
                    else if (kind == twe_pkg::K_UPDATE)
                        state_next = S_SWEEP;
                    else
                        state_next = S_DONE;
                end
            end
            S_RD:
            begin
                if (kind_reg == twe_pkg::K_INIT || queued_reg[idx_reg])
                    state_next = S_DONE;
                else if (kind_reg == twe_pkg::K_SET)
                    state_next = S_MOD;
                else if (hit_reg[idx_reg])
                    state_next = S_DONE;
                else
                    state_next = S_PROG;
            end
            S_MOD:
            begin
                if (mod_done)
                    state_next = (kind_reg == twe_pkg::K_SET) ? S_PROG : S_SWEEP;
            end
            S_PROG:  state_next = S_DONE;
            S_SWEEP:
            begin
                if (p_vld_reg && (p_idx_reg == SW'(NUM_SLOTS - 1)))
                    state_next = S_SWEND;
            end
            S_SWEND: state_next = exp_now ? S_SWEEP : S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            queued_reg    <= '0;
            hit_reg       <= '0;
            sc_reg        <= 32'd0;
            pc_reg        <= twe_pkg::TIME_MAX;
            last_tick_reg <= 64'd0;
            err_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            p_vld_reg     <= 1'b0;
            found_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                err_reg <= 1'b0;
                pv_reg  <= 1'b0;
                if ((kind == twe_pkg::K_CANCEL) && sid_ok)
                    queued_reg[sid_idx] <= 1'b0;
                if (kind == twe_pkg::K_TICK)
                    last_tick_reg <= time_value;
            end
            case (state_reg)
                S_RD:
                begin
                    if (kind_reg == twe_pkg::K_INIT)
                    begin
                        queued_reg[idx_reg] <= 1'b0;
                        hit_reg[idx_reg]    <= 1'b0;
                    end
                    else if (queued_reg[idx_reg])
                        err_reg <= 1'b1;
                    else if ((kind_reg == twe_pkg::K_SETAGAIN) && !hit_reg[idx_reg])
                    begin
                        queued_reg[idx_reg] <= 1'b1;
                        sc_reg              <= sc_reg + 32'd1;
                    end
                end
                S_MOD:
                begin
                    if (mod_done && (kind_reg == twe_pkg::K_SET))
                    begin
                        queued_reg[idx_reg] <= 1'b1;
                        sc_reg              <= sc_reg + 32'd1;
                    end
                end
                S_PROG:
                begin
                    if (cfg.one_shot && (wenq_reg < pc_reg))
                    begin
                        pv_reg <= 1'b1;
                        pc_reg <= prog_val;
                    end
                end
                S_SWEND:
                begin
                    if (exp_now)
                    begin
                        queued_reg[best_reg] <= 1'b0;
                        hit_reg[best_reg]    <= 1'b1;
                    end
                    else if (cfg.one_shot)
                    begin
                        pv_reg <= 1'b1;
                        pc_reg <= prog_val;
                    end
                end
                default: ;
            endcase
            if (state_next == S_SWEEP && state_reg != S_SWEEP)
            begin
                rd_cnt_reg <= '0;
                p_vld_reg  <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (state_reg == S_SWEEP)
            begin
                p_vld_reg <= (rd_cnt_reg < (SW+1)'(NUM_SLOTS));
                if (rd_cnt_reg < (SW+1)'(NUM_SLOTS))
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                if (p_vld_reg && (kind_reg == twe_pkg::K_TICK) && tick_cand && tick_better)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        floor_reg <= floor_sum[64] ? twe_pkg::TIME_MAX : floor_sum[63:0];
        lim_reg   <= lim_sum[64] ? twe_pkg::TIME_MAX : lim_sum[63:0];
        if (accept)
        begin
            kind_reg  <= kind;
            sid_reg   <= slot_id;
            tv_reg    <= time_value;
            ign_reg   <= ignore_valid;
            ig_reg    <= ignore_slot;
            ok_reg    <= sid_ok;
            idx_reg   <= sid_idx;
            full_reg  <= full_in;
            count_reg <= full_in ? (BW+1)'(BUCKET_COUNT) : diff[BW:0] + 1'b1;
        end
        if (state_reg == S_MOD && mod_done)
        begin
            first_reg <= full_reg ? '0 : mod_rem;
            wenq_reg  <= tv_reg;
        end
        if (state_reg == S_RD)
            wenq_reg <= r_w;
        if ((state_reg == S_SWEEP || state_reg == S_PROG || state_reg == S_SWEND) &&
            state_next == S_DONE)
            pval_reg <= prog_val;
        if (state_next == S_SWEEP && state_reg != S_SWEEP)
        begin
            if (kind_reg == twe_pkg::K_UPDATE || state_reg == S_IDLE)
                min_reg <= (state_reg == S_IDLE) ? time_value : tv_reg;
            else
                min_reg <= cfg.house_tick ? lim_reg : twe_pkg::TIME_MAX;
        end
        else if (state_reg == S_SWEEP && p_vld_reg)
        begin
            if (min_take)
                min_reg <= r_w;
            if ((kind_reg == twe_pkg::K_TICK) && tick_cand && tick_better)
            begin
                best_reg <= p_idx_reg;
                bpos_reg <= pos;
                bw_reg   <= r_w;
                bage_reg <= age;
            end
        end
        if (state_reg == S_SWEEP)
            p_idx_reg <= rd_cnt_reg[SW-1:0];
    end

    assign exp_now  = (state_reg == S_SWEND) && (kind_reg == twe_pkg::K_TICK) && found_reg;
    assign done_now = (state_reg == S_DONE);
    assign best_ext = {4'd0, best_reg};

    assign result_valid  = done_now | exp_now;
    assign event_res     = done_now;
    assign result_slot   = exp_now ? best_ext[3:0] : sid_reg;
    assign error         = done_now & err_reg;
    assign program_valid = done_now & pv_reg;
    assign program_value = (done_now & pv_reg) ? pval_reg : 64'd0;
    assign any_pending   = done_now & pend;
    assign slot_queued   = done_now & ok_reg & queued_reg[idx_reg];
    assign slot_hit      = exp_now | (done_now & ok_reg & hit_reg[idx_reg]);
    assign last          = done_now;

    a_busy_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last))
        else $error("busy dropped without a completion item");

    a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !event_res) |-> (!last && !program_valid))
        else $error("expiry item marked last or programmed");

    a_prog_only_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && program_valid) |-> cfg.one_shot)
        else $error("compare programmed outside one-shot mode");

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !mem_we)
        else $error("slot memory written during a sweep");

endmodule
`default_nettype wire

// ----- src/twe_cfg.sv -----
// Configuration registers of the timeout wheel engine behind an APB-style port.
// Depends on twe_pkg.
`default_nettype none
module twe_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output twe_pkg::cfg_t      cfg
);

    twe_pkg::cfg_t cfg_reg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_shot     <= 1'b1;
            cfg_reg.min_interval <= 32'd0;
            cfg_reg.house_tick   <= 1'b0;
            cfg_reg.grace        <= 32'd0;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                twe_pkg::R_ONE_SHOT: cfg_reg.one_shot     <= pwdata[0];
                twe_pkg::R_MIN_INT:  cfg_reg.min_interval <= pwdata;
                twe_pkg::R_HOUSE:    cfg_reg.house_tick   <= pwdata[0];
                twe_pkg::R_GRACE:    cfg_reg.grace        <= pwdata;
                default:             cfg_reg.grace        <= cfg_reg.grace;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            twe_pkg::R_ONE_SHOT: prdata = {31'd0, cfg_reg.one_shot};
            twe_pkg::R_MIN_INT:  prdata = cfg_reg.min_interval;
            twe_pkg::R_HOUSE:    prdata = {31'd0, cfg_reg.house_tick};
            twe_pkg::R_GRACE:    prdata = cfg_reg.grace;
            default:             prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/twe_mod.sv -----
// Serial remainder unit: value mod BUCKET_COUNT, eight bits a cycle.
// Depends on twe_pkg.
`default_nettype none
module twe_mod #(
    parameter int BUCKET_COUNT = twe_pkg::BUCKET_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [63:0]                     value,
    output logic                                 done,
    output logic [$clog2(BUCKET_COUNT)-1:0]      rem
);

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int RW = BW + 1;

    logic [63:0]   sh_reg;
    logic [BW-1:0] r_reg;
    logic [BW-1:0] r_next;
    logic [2:0]    cnt_reg;
    logic          act_reg;
    logic          done_reg;

    always_comb
    begin
        logic [RW-1:0] t;
        r_next = r_reg;
        for (int j = 0; j < 8; j++)
        begin
            t = {r_next, sh_reg[63-j]};
            if (t >= RW'(BUCKET_COUNT))
                t = t - RW'(BUCKET_COUNT);
            r_next = t[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                act_reg <= 1'b1;
                cnt_reg <= 3'd0;
            end
            else if (act_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    act_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= value;
            r_reg  <= '0;
        end
        else if (act_reg)
        begin
            sh_reg <= {sh_reg[55:0], 8'd0};
            r_reg  <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule
`default_nettype wire

// ----- src/twe_smem.sv -----
// Slot memory: one write and one registered read port, with per-entry written
// bits so unwritten entries read as the reset word. Depends on twe_pkg.
`default_nettype none
module twe_smem #(
    parameter int          DEPTH   = twe_pkg::NUM_SLOTS_DEF,
    parameter int          DW      = 99,
    parameter logic [DW-1:0] RST_VAL = '0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]                 rdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] wrt_reg;
    logic [DW-1:0]    q_reg;
    logic             qv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrt_reg <= '0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
                wrt_reg[waddr] <= 1'b1;
            qv_reg <= wrt_reg[raddr];
        end
    end

    assign rdata = qv_reg ? q_reg : RST_VAL;

endmodule
`default_nettype wire

// ----- dv/timeout_wheel_engine_test.sv -----
// Self-checking testbench for timeout_wheel_engine: directed table then random
// commands, each result item checked against a local timing-wheel predictor.
// Depends on twe_pkg and the timeout_wheel_engine RTL.
`timescale 1ns / 100ps
module timeout_wheel_engine_test;

    localparam int NSLOT = 16;
    localparam int NBKT = 8;
    localparam int SHIFT = 12;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic        ev;
        logic [3:0]  slot;
        logic        err;
        logic        pv;
        logic [63:0] pval;
        logic        pend;
        logic        q;
        logic        h;
        logic        lst;
    } res_t;

    typedef struct {
        logic [2:0]  k;
        logic [3:0]  sid;
        logic [63:0] tv;
        logic        iv;
        logic [3:0]  is;
        bit          chk;
        res_t        r;
    } row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy;
    logic [2:0] kind;
    logic [3:0] slot_id, ignore_slot, result_slot;
    logic [63:0] time_value, program_value;
    logic ignore_valid;
    logic result_valid, event_res, error, program_valid, any_pending;
    logic slot_queued, slot_hit, last;

    timeout_wheel_engine dut (.*);

    // predictor state
    logic [63:0] wk [NSLOT];
    bit          qf [NSLOT];
    bit          hf [NSLOT];
    logic [31:0] stp [NSLOT];
    logic [31:0] stamp_ctr;
    logic [63:0] cmp_val, last_tick;
    bit          m_one_shot, m_house;
    logic [63:0] m_min_int, m_grace;

    res_t expected_q [$];
    res_t last_pred;
    int   fails;
    int   cyc;
    bit   quiet;

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? twe_pkg::TIME_MAX : s[63:0];
    endfunction

    function automatic logic [63:0] reprogram(logic [63:0] t);
        logic [63:0] lo;
        lo = sadd(last_tick, m_min_int);
        cmp_val = (t < lo) ? lo : t;
        return cmp_val;
    endfunction

    function automatic void predict_wheel(logic [2:0] k, logic [3:0] sid,
                                          logic [63:0] tv, logic iv, logic [3:0] is);
        res_t r;
        bit pv, err, pend;
        logic [63:0] pval, sb, nb, m, lim;
        int first, cnt, b, best;
        logic [31:0] age, bage;
        bit full;
        pv = 0; err = 0; pend = 0; pval = 0;
        if (k == twe_pkg::K_INIT) begin
            wk[sid] = twe_pkg::TIME_MAX; hf[sid] = 0; qf[sid] = 0;
        end else if (k == twe_pkg::K_SET || k == twe_pkg::K_SETAGAIN) begin
            if (qf[sid]) err = 1;
            else if (k == twe_pkg::K_SET || !hf[sid]) begin
                if (k == twe_pkg::K_SET) wk[sid] = tv;
                qf[sid] = 1; stp[sid] = stamp_ctr; stamp_ctr++;
                if (m_one_shot && wk[sid] < cmp_val) begin
                    pval = reprogram(wk[sid]); pv = 1;
                end
            end
        end else if (k == twe_pkg::K_CANCEL) begin
            qf[sid] = 0;
        end else if (k == twe_pkg::K_TICK) begin
            sb = last_tick >> SHIFT;
            nb = tv >> SHIFT;
            full = (nb < sb) || (nb - sb >= NBKT);
            first = full ? 0 : int'(sb % NBKT);
            cnt = full ? NBKT : int'(nb - sb) + 1;
            last_tick = tv;
            for (int i = 0; i < cnt; i++) begin
                b = (first + i) % NBKT;
                forever begin
                    best = -1; bage = 0;
                    for (int s = 0; s < NSLOT; s++) begin
                        if (!qf[s] || ((wk[s] >> SHIFT) % NBKT) != b || wk[s] > tv)
                            continue;
                        age = stamp_ctr - stp[s];
                        if (best < 0 || wk[s] < wk[best] ||
                            (wk[s] == wk[best] && age < bage)) begin
                            best = s; bage = age;
                        end
                    end
                    if (best < 0) break;
                    qf[best] = 0; hf[best] = 1;
                    r = '0; r.slot = best[3:0]; r.h = 1;
                    expected_q.push_back(r);
                end
            end
            if (m_one_shot) begin
                lim = m_house ? sadd(tv, m_grace) : twe_pkg::TIME_MAX;
                m = lim;
                for (int s = 0; s < NSLOT; s++)
                    if (qf[s] && wk[s] < m) m = wk[s];
                pval = reprogram(m); pv = 1;
            end
        end else if (k == twe_pkg::K_UPDATE) begin
            if (m_one_shot) begin
                m = tv;
                for (int s = 0; s < NSLOT; s++)
                    if (qf[s] && !(iv && s == is) && wk[s] < m) m = wk[s];
                pval = reprogram(m); pv = 1;
            end
        end
        for (int s = 0; s < NSLOT; s++)
            if (qf[s] && !(iv && s == is)) pend = 1;
        r.ev = 1; r.slot = sid; r.err = err; r.pv = pv; r.pval = pv ? pval : 0;
        r.pend = pend; r.q = qf[sid]; r.h = hf[sid]; r.lst = 1;
        expected_q.push_back(r);
        last_pred = r;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("timeout_wheel_engine_test: FAIL");
            $finish;
        end
    end

    // result checking
    always @(posedge clk) begin
        res_t e;
        if (rst_n && result_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result item slot %0d", result_slot);
                fails++;
            end else begin
                e = expected_q.pop_front();
                if (event_res !== e.ev) begin
                    $error("event_res exp %0h got %0h", e.ev, event_res); fails++; end
                if (result_slot !== e.slot) begin
                    $error("result_slot exp %0h got %0h", e.slot, result_slot); fails++; end
                if (error !== e.err) begin
                    $error("error exp %0h got %0h", e.err, error); fails++; end
                if (program_valid !== e.pv) begin
                    $error("program_valid exp %0h got %0h", e.pv, program_valid); fails++; end
                if (program_value !== e.pval) begin
                    $error("program_value exp %0h got %0h", e.pval, program_value); fails++; end
                if (any_pending !== e.pend) begin
                    $error("any_pending exp %0h got %0h", e.pend, any_pending); fails++; end
                if (slot_queued !== e.q) begin
                    $error("slot_queued exp %0h got %0h", e.q, slot_queued); fails++; end
                if (slot_hit !== e.h) begin
                    $error("slot_hit exp %0h got %0h", e.h, slot_hit); fails++; end
                if (last !== e.lst) begin
                    $error("last exp %0h got %0h", e.lst, last); fails++; end
            end
        end
    end

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            twe_pkg::R_ONE_SHOT: m_one_shot = val[0];
            twe_pkg::R_MIN_INT:  m_min_int = {32'd0, val};
            twe_pkg::R_HOUSE:    m_house = val[0];
            default:             m_grace = {32'd0, val};
        endcase
    endtask

    task automatic issue(logic [2:0] k, logic [3:0] sid, logic [63:0] tv,
                         logic iv, logic [3:0] is);
        if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(posedge clk);
        kind <= k; slot_id <= sid; time_value <= tv; ignore_valid <= iv; ignore_slot <= is;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_wheel(k, sid, tv, iv, is);
        start <= 0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_time(logic [63:0] base);
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return twe_pkg::TIME_MAX - $urandom_range(0, 3);
            default: return base + $urandom_range(0, 40000);
        endcase
    endfunction

    initial begin
        row_t rows [$];
        row_t rw;
        logic [63:0] now;
        logic [2:0] k;
        int pick;
        cyc = 0; fails = 0; quiet = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        start = 0; kind = 0; slot_id = 0; time_value = 0; ignore_valid = 0; ignore_slot = 0;
        m_one_shot = 1; m_house = 0; m_min_int = 0; m_grace = 0;
        for (int s = 0; s < NSLOT; s++) begin
            wk[s] = twe_pkg::TIME_MAX; qf[s] = 0; hf[s] = 0; stp[s] = 0;
        end
        stamp_ctr = 0; cmp_val = twe_pkg::TIME_MAX; last_tick = 0;
        last_pred = '0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: k, sid, tv, iv, is, typed check, typed result
        rows.push_back('{twe_pkg::K_UPDATE, 4'd0, twe_pkg::TIME_MAX, 1'b0, 4'd0, 1,
                         '{1, 4'd0, 0, 1, twe_pkg::TIME_MAX, 0, 0, 0, 1}});
        rows.push_back('{3'd6, 4'd15, 64'd0, 1'b0, 4'd0, 1, '{1, 4'd15, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{3'd7, 4'd3, twe_pkg::TIME_MAX, 1'b1, 4'd15, 1,
                         '{1, 4'd3, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{twe_pkg::K_SET, 4'd0, 64'd100, 0, 0, 1,
                         '{1, 4'd0, 0, 1, 64'd100, 1, 1, 0, 1}});
        rows.push_back('{twe_pkg::K_SET, 4'd0, 64'd5, 0, 0, 1,
                         '{1, 4'd0, 1, 0, 0, 1, 1, 0, 1}});
        rows.push_back('{twe_pkg::K_SETAGAIN, 4'd0, 64'd0, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SET, 4'd1, 64'd100, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SET, 4'd2, 64'd100, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SET, 4'd3, 64'h5000, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SET, 4'd15, twe_pkg::TIME_MAX, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_UPDATE, 4'd0, 64'd50, 1, 4'd15, 0, '0});
        rows.push_back('{twe_pkg::K_CANCEL, 4'd1, 64'd0, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_TICK, 4'd0, 64'h1000, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SETAGAIN, 4'd0, 64'd0, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_TICK, 4'd0, 64'h9000, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_TICK, 4'd0, 64'h10, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_TICK, 4'd0, twe_pkg::TIME_MAX, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_INIT, 4'd0, 64'd0, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_SETAGAIN, 4'd0, 64'd0, 0, 0, 0, '0});
        rows.push_back('{twe_pkg::K_UPDATE, 4'd0, 64'd0, 1, 4'd0, 0, '0});
        foreach (rows[i]) begin
            rw = rows[i];
            issue(rw.k, rw.sid, rw.tv, rw.iv, rw.is);
            if (rw.chk && last_pred != rw.r) begin
                $error("directed row %0d prediction differs from table", i);
                fails++;
            end
        end
        wait_drained();
        for (int s = 0; s < NSLOT; s++) issue(twe_pkg::K_INIT, s[3:0], 0, 0, 0);
        issue(twe_pkg::K_TICK, 0, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin cfg_write(twe_pkg::R_ONE_SHOT, 1);
                         cfg_write(twe_pkg::R_MIN_INT, 32'hFFFF_FFFF);
                         cfg_write(twe_pkg::R_HOUSE, 1); cfg_write(twe_pkg::R_GRACE, 0); end
                1: begin cfg_write(twe_pkg::R_MIN_INT, 300);
                         cfg_write(twe_pkg::R_GRACE, 32'hFFFF_FFFF); end
                2: begin cfg_write(twe_pkg::R_ONE_SHOT, 0); cfg_write(twe_pkg::R_HOUSE, 0); end
                default: begin cfg_write(twe_pkg::R_ONE_SHOT, 1);
                               cfg_write(twe_pkg::R_MIN_INT, 0);
                               cfg_write(twe_pkg::R_GRACE, 5000); end
            endcase
            now = last_tick;
            quiet = (ph == 3);
            for (int n = 0; n < 45; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 7) k = twe_pkg::K_SET;
                else if (pick < 9) k = twe_pkg::K_SETAGAIN;
                else if (pick < 11) k = twe_pkg::K_CANCEL;
                else if (pick < 12) k = twe_pkg::K_INIT;
                else if (pick < 16) k = twe_pkg::K_TICK;
                else if (pick < 19) k = twe_pkg::K_UPDATE;
                else k = 3'($urandom_range(6, 7));
                if (k == twe_pkg::K_TICK) begin
                    if ($urandom_range(0, 9) == 0) now = rand_time(0);
                    else now = now + $urandom_range(0, 20000);
                    issue(k, 4'($urandom), now, 1'($urandom), 4'($urandom));
                end else if (k == twe_pkg::K_SET)
                    issue(k, 4'($urandom), rand_time(now), 1'($urandom), 4'($urandom));
                else
                    issue(k, 4'($urandom), rand_time(now), 1'($urandom), 4'($urandom));
            end
            wait_drained();
        end

        if (fails == 0)
            $display("timeout_wheel_engine_test: PASS");
        else
            $display("timeout_wheel_engine_test: FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
src/twe_pkg.sv
src/twe_cfg.sv
src/twe_mod.sv
src/twe_smem.sv
src/timeout_wheel_engine.sv
dv/timeout_wheel_engine_test.sv
